// ===== rtl/core/dlp_pkg.sv =====
// Shared types, result codes and character constants of the directory line parser.
// No dependencies; imported by the top level and dlp_scan.
`default_nettype none

package dlp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       read_status_bad;
    logic       open_failed;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  entry_status;
    logic [3:0]  file_type;
    logic [15:0] block_count;
    logic        read_only;
    logic [1:0]  char_kind;
    logic [3:0]  char_index;
    logic [7:0]  char_value;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic        start;
    logic [15:0] size;
    logic [7:0]  first;
  } scan_cmd_t;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NOT_READY = 3'd1;
  localparam logic [2:0] STAT_AT_START  = 3'd2;
  localparam logic [2:0] STAT_READ_ERR  = 3'd3;
  localparam logic [2:0] STAT_TOO_SHORT = 3'd4;

  localparam logic [3:0] FT_HEADER = 4'd9;
  localparam logic [3:0] FT_FREE   = 4'd10;

  localparam logic [1:0] KIND_SUM  = 2'd0;
  localparam logic [1:0] KIND_NAME = 2'd1;
  localparam logic [1:0] KIND_ID   = 2'd2;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BLANK   = 8'h20;
  localparam logic [7:0] CH_SHBLANK = 8'hA0;
  localparam logic [7:0] CH_LOCK    = 8'h3C;
  localparam logic [7:0] CH_FREE    = 8'h62;

  localparam logic [4:0] NAME_MAX = 5'd16;
  localparam logic [3:0] ID_LAST  = 4'd4;
  localparam int unsigned MIN_LEN = 5;

  localparam logic [23:0] SUFFIX_TAB [9] = '{
    "prg", "seq", "usr", "del", "rel", "cbm", "dir", "vrp", "lnk"
  };

  function automatic logic is_blank(logic [7:0] c);
    return (c == 8'h00) || (c == CH_BLANK) || (c == CH_SHBLANK);
  endfunction

  // {hit, type}; first match in table order wins
  function automatic logic [4:0] suffix_match(logic [7:0] c0, logic [7:0] c1,
                                               logic [7:0] c2);
    logic [4:0] r;
    r = {1'b0, FT_HEADER};
    for (int k = 8; k >= 0; k--) begin
      if ({c0, c1, c2} == SUFFIX_TAB[k]) begin
        r = {1'b1, 4'(k)};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/directory_listing_line_parser.sv =====
// Top level of the directory listing line parser: entry byte tracking, line store
// writes and the output register. Uses dlp_pkg, dlp_line_mem and dlp_scan.
//
//   port group            dir  beat type    accepted when
//   in_valid_i/in_stall_o in   in_beat_t    in_valid_i & !in_stall_o
//   out_valid_o/out_stall_i out out_beat_t  out_valid_o & !out_stall_i
//
// Entry bytes are taken while the input is not stalled. At the zero byte the scan
// walks the stored line through the memory's single read port, issuing each read
// and then taking its registered data. Input stalls while the scan runs and while
// a result beat waits. Reset leaves the block at the start of an entry; no
// clearing pass.
`default_nettype none

module directory_listing_line_parser
  import dlp_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_data_o
);

  localparam int unsigned AW = $clog2(LINE_BYTES);
  localparam int unsigned LW = $clog2(LINE_BYTES + 1);

  logic [1:0]    pos_q;
  logic          in_text_q;
  logic [15:0]   size_q;
  logic [LW-1:0] len_q;
  logic [7:0]    first_q;
  logic          out_valid_q;
  out_beat_t     out_q;

  logic          in_acc, out_free;
  logic          in_item;
  out_beat_t     in_item_beat;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  scan_cmd_t     cmd;
  logic          scan_valid, scan_ack, scan_busy;
  out_beat_t     scan_beat;

  assign in_stall_o  = scan_busy || out_valid_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign scan_ack    = scan_valid && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign wr_en = in_acc && in_text_q && (in_data_i.data_byte != 8'h00) &&
                 (len_q < LW'(LINE_BYTES));

  assign cmd.start = in_acc && in_text_q && (in_data_i.data_byte == 8'h00);
  assign cmd.size  = size_q;
  assign cmd.first = first_q;

  always_comb begin
    in_item      = 1'b0;
    in_item_beat = '0;
    in_item_beat.last = 1'b1;
    if (in_acc) begin
      if (!in_text_q) begin
        if (pos_q == 2'd0) begin
          if (in_data_i.open_failed) begin
            in_item = 1'b1;
            in_item_beat.entry_status = STAT_NOT_READY;
          end else if (in_data_i.read_status_bad) begin
            in_item = 1'b1;
            in_item_beat.entry_status = STAT_AT_START;
          end
        end
      end else if (in_data_i.data_byte != 8'h00 && in_data_i.read_status_bad) begin
        in_item = 1'b1;
        in_item_beat.entry_status = STAT_READ_ERR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= 2'd0;
      in_text_q <= 1'b0;
      len_q     <= '0;
      first_q   <= 8'h00;
    end else if (in_acc) begin
      if (!in_text_q) begin
        if (pos_q == 2'd0) begin
          if (!in_data_i.open_failed && !in_data_i.read_status_bad) begin
            len_q   <= '0;
            first_q <= 8'h00;
            pos_q   <= 2'd1;
          end
        end else if (pos_q == 2'd3) begin
          pos_q     <= 2'd0;
          in_text_q <= 1'b1;
        end else begin
          pos_q <= pos_q + 2'd1;
        end
      end else if (in_data_i.data_byte == 8'h00) begin
        in_text_q <= 1'b0;
      end else begin
        if (wr_en) begin
          len_q <= len_q + LW'(1);
          if (len_q == '0) begin
            first_q <= in_data_i.data_byte;
          end
        end
        if (in_data_i.read_status_bad) begin
          in_text_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 16'h0000;
    end else if (in_acc && !in_text_q) begin
      if (pos_q == 2'd2) begin
        size_q <= {8'h00, in_data_i.data_byte};
      end else if (pos_q == 2'd3) begin
        size_q <= {in_data_i.data_byte, size_q[7:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_item || scan_ack) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_item) begin
      out_q <= in_item_beat;
    end else if (scan_ack) begin
      out_q <= scan_beat;
    end
  end

  dlp_line_mem #(
    .DEPTH(LINE_BYTES)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(len_q[AW-1:0]),
    .wr_data_i(in_data_i.data_byte),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  dlp_scan #(
    .LINE_BYTES(LINE_BYTES)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .len_i       (len_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .item_valid_o(scan_valid),
    .item_o      (scan_beat),
    .item_ack_i  (scan_ack),
    .busy_o      (scan_busy)
  );

endmodule

`default_nettype wire

// ===== rtl/core/dlp_line_mem.sv =====
// Line text store: one write port, one registered read port.
// Depends on nothing; instantiated by the top level.
`default_nettype none

module dlp_line_mem #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [7:0]               wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [7:0]               rd_data_o
);

  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dlp_scan.sv =====
// End-of-line sequencer: trims, finds lock mark, suffix, name and disk ID, emits results.
// Reads the line store through dlp_line_mem; types and constants from dlp_pkg.
`default_nettype none

module dlp_scan
  import dlp_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire scan_cmd_t                         cmd_i,
  input  wire logic [$clog2(LINE_BYTES+1)-1:0]   len_i,
  output logic                                   rd_en_o,
  output logic      [$clog2(LINE_BYTES)-1:0]     rd_addr_o,
  input  wire logic [7:0]                        rd_data_i,
  output logic                                   item_valid_o,
  output out_beat_t                              item_o,
  input  wire logic                              item_ack_i,
  output logic                                   busy_o
);

  localparam int unsigned AW = $clog2(LINE_BYTES);
  localparam int unsigned LW = $clog2(LINE_BYTES + 1);
  localparam int unsigned PW = LW + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLASS = 9'b000000010,
    S_TRIM  = 9'b000000100,
    S_SUFX  = 9'b000001000,
    S_QUOTE = 9'b000010000,
    S_NAME  = 9'b000100000,
    S_SKIP  = 9'b001000000,
    S_SUM   = 9'b010000000,
    S_CHAR  = 9'b100000000
  } scan_state_e;

  scan_state_e state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [15:0]   size_q, size_d;
  logic [7:0]    first_q, first_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic          wait_q, wait_d;
  logic          rng_q, rng_d;
  logic [1:0]    sub_q, sub_d;
  logic [7:0]    sfx0_q, sfx0_d, sfx1_q, sfx1_d;
  logic          ro_q, ro_d;
  logic [3:0]    ty_q, ty_d;
  logic          hdr_q, hdr_d;
  logic [PW-1:0] nstart_q, nstart_d;
  logic [4:0]    nl_q, nl_d, nlt_q, nlt_d;
  logic [PW-1:0] idst_q, idst_d;
  logic [1:0]    kind_q, kind_d;
  logic [3:0]    cidx_q, cidx_d;

  logic [7:0]    rdat;
  logic [PW-1:0] len_w;
  logic          trim_done, name_done;
  logic [7:0]    lastc;
  logic [PW-1:0] mlen;
  logic [4:0]    match;
  logic          name_end;

  assign rdat     = rng_q ? rd_data_i : 8'h00;
  assign len_w    = PW'(len_q);
  assign name_end = ({1'b0, cidx_q} + 5'd1) == nl_q;
  assign busy_o   = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    size_d   = size_q;
    first_d  = first_q;
    ptr_d    = ptr_q;
    wait_d   = wait_q;
    rng_d    = rng_q;
    sub_d    = sub_q;
    sfx0_d   = sfx0_q;
    sfx1_d   = sfx1_q;
    ro_d     = ro_q;
    ty_d     = ty_q;
    hdr_d    = hdr_q;
    nstart_d = nstart_q;
    nl_d     = nl_q;
    nlt_d    = nlt_q;
    idst_d   = idst_q;
    kind_d   = kind_q;
    cidx_d   = cidx_q;
    rd_en_o   = 1'b0;
    rd_addr_o = ptr_q[AW-1:0];
    item_valid_o = 1'b0;
    item_o       = '0;
    trim_done = 1'b0;
    name_done = 1'b0;
    lastc     = 8'h00;
    mlen      = '0;
    match     = suffix_match(sfx0_q, sfx1_q, rdat);

    if (!wait_q && state_q != S_IDLE && state_q != S_CLASS && state_q != S_SUM) begin
      rng_d = ptr_q < len_w;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.start) begin
          len_d   = len_i;
          size_d  = cmd_i.size;
          first_d = cmd_i.first;
          wait_d  = 1'b0;
          hdr_d   = 1'b0;
          ro_d    = 1'b0;
          state_d = S_CLASS;
        end
      end
      S_CLASS: begin
        if (first_q == CH_FREE) begin
          item_valid_o       = 1'b1;
          item_o.entry_status = STAT_OK;
          item_o.file_type   = FT_FREE;
          item_o.block_count = size_q;
          item_o.last        = 1'b1;
          if (item_ack_i) begin
            state_d = S_IDLE;
          end
        end else if (len_q < LW'(MIN_LEN)) begin
          item_valid_o        = 1'b1;
          item_o.entry_status = STAT_TOO_SHORT;
          item_o.last         = 1'b1;
          if (item_ack_i) begin
            state_d = S_IDLE;
          end
        end else begin
          ptr_d   = len_w - PW'(1);
          state_d = S_TRIM;
        end
      end
      S_TRIM: begin
        if (!wait_q) begin
          if (len_q == '0) begin
            trim_done = 1'b1;
          end else begin
            rd_en_o = 1'b1;
            wait_d  = 1'b1;
          end
        end else begin
          wait_d = 1'b0;
          if (is_blank(rdat)) begin
            len_d = len_q - LW'(1);
            ptr_d = ptr_q - PW'(1);
          end else begin
            trim_done = 1'b1;
            lastc     = rdat;
          end
        end
        if (trim_done) begin
          ro_d = (lastc == CH_LOCK);
          mlen = len_w - PW'(lastc == CH_LOCK);
          if (mlen >= PW'(3)) begin
            ptr_d   = mlen - PW'(3);
            sub_d   = 2'd0;
            state_d = S_SUFX;
          end else begin
            hdr_d   = 1'b1;
            ty_d    = FT_HEADER;
            ro_d    = 1'b0;
            ptr_d   = '0;
            state_d = S_QUOTE;
          end
        end
      end
      S_SUFX: begin
        if (!wait_q) begin
          rd_en_o = 1'b1;
          wait_d  = 1'b1;
        end else begin
          wait_d = 1'b0;
          ptr_d  = ptr_q + PW'(1);
          if (sub_q == 2'd0) begin
            sfx0_d = rdat;
            sub_d  = 2'd1;
          end else if (sub_q == 2'd1) begin
            sfx1_d = rdat;
            sub_d  = 2'd2;
          end else begin
            ty_d  = match[3:0];
            hdr_d = !match[4];
            if (!match[4]) begin
              ro_d = 1'b0;
            end
            ptr_d   = '0;
            state_d = S_QUOTE;
          end
        end
      end
      S_QUOTE: begin
        if (!wait_q) begin
          if (ptr_q >= len_w) begin
            ptr_d    = PW'(LINE_BYTES);
            nstart_d = PW'(LINE_BYTES);
            nl_d     = '0;
            nlt_d    = '0;
            state_d  = S_NAME;
          end else begin
            rd_en_o = 1'b1;
            wait_d  = 1'b1;
          end
        end else begin
          wait_d = 1'b0;
          ptr_d  = ptr_q + PW'(1);
          if (rdat == CH_QUOTE) begin
            nstart_d = ptr_q + PW'(1);
            nl_d     = '0;
            nlt_d    = '0;
            state_d  = S_NAME;
          end
        end
      end
      S_NAME: begin
        if (!wait_q) begin
          if (ptr_q >= len_w || nl_q == NAME_MAX) begin
            name_done = 1'b1;
          end else begin
            rd_en_o = 1'b1;
            wait_d  = 1'b1;
          end
        end else begin
          wait_d = 1'b0;
          if (rdat == CH_QUOTE) begin
            name_done = 1'b1;
          end else begin
            nl_d  = nl_q + 5'd1;
            ptr_d = ptr_q + PW'(1);
            if (!is_blank(rdat)) begin
              nlt_d = nl_q + 5'd1;
            end
          end
        end
        if (name_done) begin
          if (hdr_q) begin
            if (nl_q != '0) begin
              nl_d = (nlt_q == '0) ? 5'd1 : nlt_q;
            end
            sub_d   = 2'd0;
            state_d = S_SKIP;
          end else begin
            state_d = S_SUM;
          end
        end
      end
      S_SKIP: begin
        if (!wait_q) begin
          rd_en_o = 1'b1;
          wait_d  = 1'b1;
        end else begin
          wait_d = 1'b0;
          if (sub_q == 2'd0) begin
            ptr_d = ptr_q + PW'(rdat == CH_QUOTE);
            sub_d = 2'd1;
          end else begin
            ptr_d   = ptr_q + PW'(rdat == CH_BLANK);
            idst_d  = ptr_q + PW'(rdat == CH_BLANK);
            state_d = S_SUM;
          end
        end
      end
      S_SUM: begin
        item_valid_o        = 1'b1;
        item_o.entry_status = STAT_OK;
        item_o.file_type    = ty_q;
        item_o.block_count  = size_q;
        item_o.read_only    = ro_q;
        item_o.char_kind    = KIND_SUM;
        item_o.last         = !hdr_q && (nl_q == '0);
        if (item_ack_i) begin
          wait_d = 1'b0;
          cidx_d = '0;
          if (nl_q != '0) begin
            kind_d  = KIND_NAME;
            ptr_d   = nstart_q;
            state_d = S_CHAR;
          end else if (hdr_q) begin
            kind_d  = KIND_ID;
            ptr_d   = idst_q;
            state_d = S_CHAR;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_CHAR: begin
        if (!wait_q) begin
          rd_en_o = 1'b1;
          wait_d  = 1'b1;
        end else begin
          item_valid_o        = 1'b1;
          item_o.entry_status = STAT_OK;
          item_o.file_type    = ty_q;
          item_o.block_count  = size_q;
          item_o.read_only    = ro_q;
          item_o.char_kind    = kind_q;
          item_o.char_index   = cidx_q;
          item_o.char_value   = rdat;
          item_o.last         = (kind_q == KIND_NAME) ? (!hdr_q && name_end)
                                                      : (cidx_q == ID_LAST);
          if (item_ack_i) begin
            wait_d = 1'b0;
            if (kind_q == KIND_NAME && name_end) begin
              if (hdr_q) begin
                kind_d = KIND_ID;
                ptr_d  = idst_q;
                cidx_d = '0;
              end else begin
                state_d = S_IDLE;
              end
            end else if (kind_q == KIND_ID && cidx_q == ID_LAST) begin
              state_d = S_IDLE;
            end else begin
              cidx_d = cidx_q + 4'd1;
              ptr_d  = ptr_q + PW'(1);
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    size_q   <= size_d;
    first_q  <= first_d;
    ptr_q    <= ptr_d;
    rng_q    <= rng_d;
    sub_q    <= sub_d;
    sfx0_q   <= sfx0_d;
    sfx1_q   <= sfx1_d;
    ro_q     <= ro_d;
    ty_q     <= ty_d;
    hdr_q    <= hdr_d;
    nstart_q <= nstart_d;
    nl_q     <= nl_d;
    nlt_q    <= nlt_d;
    idst_q   <= idst_d;
    kind_q   <= kind_d;
    cidx_q   <= cidx_d;
  end

endmodule

`default_nettype wire
